// ===== hdl/ctls_pkg.sv =====
// ============================================================================
// ctls_pkg
// Shared types, codes, keyword table and character helpers for the C-like
// token scanner.
// ============================================================================
package ctls_pkg;

   // Widths and sizes
   localparam int PosBits      = 24;
   localparam int FieldBits    = 24;
   localparam int KindBits     = 6;
   localparam int StateBits    = 5;
   localparam int PrefixBits   = 64;
   localparam int CountBits    = 4;
   localparam int MaxTokens    = 3;
   localparam int GroupBits    = $clog2(MaxTokens + 1);
   localparam int QueueDepth   = 8;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int NumKeywords  = 18;
   localparam int RspDataBits  = 56;
   localparam int RspPadBits   = RspDataBits - KindBits - 2 * FieldBits;

   localparam logic [CountBits-1:0] PrefixBytes   = 4'd8;
   localparam logic [CountBits-1:0] IdentCountMax = 4'd9;

   // Scanner states
   localparam logic [StateBits-1:0] StStart     = 5'd0;
   localparam logic [StateBits-1:0] StIdent     = 5'd1;
   localparam logic [StateBits-1:0] StNumber    = 5'd2;
   localparam logic [StateBits-1:0] StString    = 5'd3;
   localparam logic [StateBits-1:0] StEscape    = 5'd4;
   localparam logic [StateBits-1:0] StPlus      = 5'd5;
   localparam logic [StateBits-1:0] StMinus     = 5'd6;
   localparam logic [StateBits-1:0] StLess      = 5'd7;
   localparam logic [StateBits-1:0] StGreater   = 5'd8;
   localparam logic [StateBits-1:0] StEqual     = 5'd9;
   localparam logic [StateBits-1:0] StBang      = 5'd10;
   localparam logic [StateBits-1:0] StAmp       = 5'd11;
   localparam logic [StateBits-1:0] StBar       = 5'd12;
   localparam logic [StateBits-1:0] StDot       = 5'd13;
   localparam logic [StateBits-1:0] StDot2      = 5'd14;
   localparam logic [StateBits-1:0] StSlash     = 5'd15;
   localparam logic [StateBits-1:0] StLineCmt   = 5'd16;
   localparam logic [StateBits-1:0] StBlockCmt  = 5'd17;
   localparam logic [StateBits-1:0] StBlockStar = 5'd18;

   // Token kinds
   localparam logic [KindBits-1:0] KNumber   = 6'd0;
   localparam logic [KindBits-1:0] KIdent    = 6'd1;
   localparam logic [KindBits-1:0] KString   = 6'd2;
   localparam logic [KindBits-1:0] KPlus     = 6'd3;
   localparam logic [KindBits-1:0] KPlus2    = 6'd4;
   localparam logic [KindBits-1:0] KMinus    = 6'd5;
   localparam logic [KindBits-1:0] KMinus2   = 6'd6;
   localparam logic [KindBits-1:0] KArrow    = 6'd7;
   localparam logic [KindBits-1:0] KLt       = 6'd8;
   localparam logic [KindBits-1:0] KLe       = 6'd9;
   localparam logic [KindBits-1:0] KShl      = 6'd10;
   localparam logic [KindBits-1:0] KGt       = 6'd11;
   localparam logic [KindBits-1:0] KGe       = 6'd12;
   localparam logic [KindBits-1:0] KShr      = 6'd13;
   localparam logic [KindBits-1:0] KAssign   = 6'd14;
   localparam logic [KindBits-1:0] KEq       = 6'd15;
   localparam logic [KindBits-1:0] KNot      = 6'd16;
   localparam logic [KindBits-1:0] KNe       = 6'd17;
   localparam logic [KindBits-1:0] KAnd      = 6'd18;
   localparam logic [KindBits-1:0] KLand     = 6'd19;
   localparam logic [KindBits-1:0] KOr       = 6'd20;
   localparam logic [KindBits-1:0] KLor      = 6'd21;
   localparam logic [KindBits-1:0] KDot      = 6'd22;
   localparam logic [KindBits-1:0] KEllipsis = 6'd23;
   localparam logic [KindBits-1:0] KDiv      = 6'd24;
   localparam logic [KindBits-1:0] KLparen   = 6'd25;
   localparam logic [KindBits-1:0] KRparen   = 6'd26;
   localparam logic [KindBits-1:0] KLbracket = 6'd27;
   localparam logic [KindBits-1:0] KRbracket = 6'd28;
   localparam logic [KindBits-1:0] KLbrace   = 6'd29;
   localparam logic [KindBits-1:0] KRbrace   = 6'd30;
   localparam logic [KindBits-1:0] KColon    = 6'd31;
   localparam logic [KindBits-1:0] KSemi     = 6'd32;
   localparam logic [KindBits-1:0] KComma    = 6'd33;
   localparam logic [KindBits-1:0] KTilde    = 6'd34;
   localparam logic [KindBits-1:0] KXor      = 6'd35;
   localparam logic [KindBits-1:0] KStar     = 6'd36;
   localparam logic [KindBits-1:0] KPercent  = 6'd37;
   localparam logic [KindBits-1:0] KKeyword0 = 6'd38;
   localparam logic [KindBits-1:0] KEof      = 6'd56;
   localparam logic [KindBits-1:0] KError    = 6'd57;

   // Keyword text, first character in the low byte, zero padded
   localparam logic [PrefixBits-1:0] KeywordText [NumKeywords] = '{
      64'h0000_006b_6165_7262,   // break
      64'h0000_0000_6573_6163,   // case
      64'h0000_0000_7473_6163,   // cast
      64'h0000_0000_7261_6863,   // char
      64'h6575_6e69_746e_6f63,   // continue
      64'h0074_6c75_6166_6564,   // default
      64'h0000_0000_0000_6f64,   // do
      64'h0000_656c_6275_6f64,   // double
      64'h0000_0000_6573_6c65,   // else
      64'h0000_0000_0072_6f66,   // for
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_0074_6e69,   // int
      64'h0000_6e72_7574_6572,   // return
      64'h0000_7463_7572_7473,   // struct
      64'h0000_6863_7469_7773,   // switch
      64'h0066_6564_6570_7974,   // typedef
      64'h0000_0000_6469_6f76,   // void
      64'h0000_0065_6c69_6877    // while
   };

   localparam logic [CountBits-1:0] KeywordLen [NumKeywords] = '{
      4'd5, 4'd4, 4'd4, 4'd4, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4,
      4'd3, 4'd2, 4'd3, 4'd6, 4'd6, 4'd6, 4'd7, 4'd4, 4'd5
   };

   // One result token
   typedef struct packed {
      logic [KindBits-1:0]  kind;
      logic [FieldBits-1:0] offset;
      logic [FieldBits-1:0] length;
      logic                 last;
   } token_type;

   // Tokens produced by one source byte, compacted into the low slots
   typedef struct packed {
      logic [GroupBits-1:0]            count;
      token_type [MaxTokens-1:0]       slot;
   } token_group_type;

   // Outcome of scanning a byte from the start state
   typedef struct packed {
      logic [StateBits-1:0] state;
      logic                 done;
      logic [KindBits-1:0]  kind;
      logic                 restart;
   } start_step_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic [FieldBits-1:0] sat_inc(input logic [FieldBits-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Single-character punctuators; anything else is a stray byte
   function automatic logic [KindBits-1:0] single_kind(input logic [7:0] c);
      logic [KindBits-1:0] k;
      unique case (c)
         "(":     k = KLparen;
         ")":     k = KRparen;
         "[":     k = KLbracket;
         "]":     k = KRbracket;
         "{":     k = KLbrace;
         "}":     k = KRbrace;
         ":":     k = KColon;
         ";":     k = KSemi;
         ",":     k = KComma;
         "~":     k = KTilde;
         "^":     k = KXor;
         "*":     k = KStar;
         "%":     k = KPercent;
         default: k = KError;
      endcase
      return k;
   endfunction

   // Start-state transition for one byte
   function automatic start_step_type start_step(input logic [7:0] c);
      start_step_type s;
      s.state   = StStart;
      s.done    = 1'b0;
      s.kind    = KError;
      s.restart = 1'b0;
      priority if (is_space(c)) s.restart = 1'b1;
      else if (is_alpha(c)) s.state = StIdent;
      else if (is_digit(c)) s.state = StNumber;
      else if (c == "\"")   s.state = StString;
      else if (c == "+")    s.state = StPlus;
      else if (c == "-")    s.state = StMinus;
      else if (c == "<")    s.state = StLess;
      else if (c == ">")    s.state = StGreater;
      else if (c == "=")    s.state = StEqual;
      else if (c == "!")    s.state = StBang;
      else if (c == "&")    s.state = StAmp;
      else if (c == "|")    s.state = StBar;
      else if (c == ".")    s.state = StDot;
      else if (c == "/")    s.state = StSlash;
      else begin
         s.done    = 1'b1;
         s.kind    = single_kind(c);
         s.restart = 1'b1;
      end
      return s;
   endfunction

   // Identifier or keyword; unused prefix bytes are always zero
   function automatic logic [KindBits-1:0] keyword_kind(
      input logic [PrefixBits-1:0] prefix,
      input logic [CountBits-1:0]  count
   );
      logic [KindBits-1:0] k;
      k = KIdent;
      for (int i = 0; i < NumKeywords; i++) begin
         if (count == KeywordLen[i] && prefix == KeywordText[i])
            k = KKeyword0 + KindBits'(i);
      end
      return k;
   endfunction

endpackage

// ===== hdl/ctls_scan_core.sv =====
// ============================================================================
// ctls_scan_core
// Scanner state registers and the single-pass next-state and token logic.
// A byte that ends a pending token is rescanned from the start state in
// the same cycle; end of text flushes the pending token and adds EOF.
// ============================================================================
module ctls_scan_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,       // byte is consumed this cycle
   input  logic [7:0]                src_byte,
   input  logic                      src_last,
   output ctls_pkg::token_group_type group
);

   logic [ctls_pkg::StateBits-1:0]  state_ff, state_in, st_a;
   logic [ctls_pkg::PosBits-1:0]    pos_ff, pos_in, pos_next;
   logic [ctls_pkg::PosBits-1:0]    start_ff, start_in, start_mid, start_b;
   logic [ctls_pkg::FieldBits-1:0]  span_ff, span_in, span_mid, span_b;
   logic [ctls_pkg::PrefixBits-1:0] prefix_ff, prefix_in, prefix_a;
   logic [ctls_pkg::CountBits-1:0]  count_ff, count_in, count_a;

   ctls_pkg::start_step_type        s;
   logic                            restart, done1, prev1, close1, run_start;
   logic [ctls_pkg::KindBits-1:0]   kind1, end_kind;
   ctls_pkg::token_type             cand [4];
   logic [3:0]                      cand_valid;
   logic [ctls_pkg::GroupBits-1:0]  n;

   assign s        = ctls_pkg::start_step(src_byte);
   assign pos_next = pos_ff + 1'b1;

   // First pass from the current state, second pass from start on a rescan
   always_comb begin
      st_a      = state_ff;
      restart   = 1'b0;
      done1     = 1'b0;
      prev1     = 1'b0;
      close1    = 1'b0;
      run_start = 1'b0;
      kind1     = ctls_pkg::KError;
      prefix_a  = prefix_ff;
      count_a   = count_ff;

      unique case (state_ff)
         ctls_pkg::StIdent: begin
            if (ctls_pkg::is_alpha(src_byte) || ctls_pkg::is_digit(src_byte)) begin
               if (count_ff < ctls_pkg::PrefixBytes)
                  prefix_a[{count_ff[2:0], 3'b000} +: 8] = src_byte;
               if (count_ff < ctls_pkg::IdentCountMax)
                  count_a = count_ff + 1'b1;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::keyword_kind(prefix_ff, count_ff);
            end
         end
         ctls_pkg::StNumber: begin
            if (!ctls_pkg::is_digit(src_byte)) begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KNumber;
            end
         end
         ctls_pkg::StString: begin
            if (src_byte == "\"") begin
               close1  = 1'b1;
               st_a    = ctls_pkg::StStart;
               restart = 1'b1;
            end else if (src_byte == "\\") begin
               st_a = ctls_pkg::StEscape;
            end
         end
         ctls_pkg::StEscape: begin
            if (src_byte == "n" || src_byte == "t" || src_byte == "r" ||
                src_byte == "~" || src_byte == "\"" || src_byte == "\\") begin
               st_a = ctls_pkg::StString;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KError;
            end
         end
         ctls_pkg::StPlus: begin
            done1 = (src_byte == "+");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KPlus2 : ctls_pkg::KPlus;
         end
         ctls_pkg::StMinus: begin
            priority if (src_byte == "-") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KMinus2;
            end else if (src_byte == ">") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KArrow;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KMinus;
            end
         end
         ctls_pkg::StLess: begin
            priority if (src_byte == "<") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KShl;
            end else if (src_byte == "=") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KLe;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KLt;
            end
         end
         ctls_pkg::StGreater: begin
            priority if (src_byte == ">") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KShr;
            end else if (src_byte == "=") begin
               done1 = 1'b1;
               kind1 = ctls_pkg::KGe;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KGt;
            end
         end
         ctls_pkg::StEqual: begin
            done1 = (src_byte == "=");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KEq : ctls_pkg::KAssign;
         end
         ctls_pkg::StBang: begin
            done1 = (src_byte == "=");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KNe : ctls_pkg::KNot;
         end
         ctls_pkg::StAmp: begin
            done1 = (src_byte == "&");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KLand : ctls_pkg::KAnd;
         end
         ctls_pkg::StBar: begin
            done1 = (src_byte == "|");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KLor : ctls_pkg::KOr;
         end
         ctls_pkg::StDot: begin
            if (src_byte == ".") begin
               st_a = ctls_pkg::StDot2;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KDot;
            end
         end
         ctls_pkg::StDot2: begin
            done1 = (src_byte == ".");
            prev1 = !done1;
            kind1 = done1 ? ctls_pkg::KEllipsis : ctls_pkg::KError;
         end
         ctls_pkg::StSlash: begin
            priority if (src_byte == "/") begin
               st_a    = ctls_pkg::StLineCmt;
               restart = 1'b1;
            end else if (src_byte == "*") begin
               st_a    = ctls_pkg::StBlockCmt;
               restart = 1'b1;
            end else begin
               prev1 = 1'b1;
               kind1 = ctls_pkg::KDiv;
            end
         end
         ctls_pkg::StLineCmt: begin
            if (src_byte == 8'h0A) begin
               st_a    = ctls_pkg::StStart;
               restart = 1'b1;
            end
         end
         ctls_pkg::StBlockCmt: begin
            if (src_byte == "*")
               st_a = ctls_pkg::StBlockStar;
         end
         ctls_pkg::StBlockStar: begin
            priority if (src_byte == "/") begin
               st_a    = ctls_pkg::StStart;
               restart = 1'b1;
            end else if (src_byte != "*") begin
               st_a = ctls_pkg::StBlockCmt;
            end
         end
         default: run_start = 1'b1;   // start state
      endcase

      if (done1) begin
         st_a    = ctls_pkg::StStart;
         restart = 1'b1;
      end

      // rescan from start after a pending token closed
      if (prev1 || run_start) begin
         st_a    = s.state;
         restart = restart | s.restart;
         if (s.state == ctls_pkg::StIdent) begin
            prefix_a = {{(ctls_pkg::PrefixBits - 8){1'b0}}, src_byte};
            count_a  = 4'd1;
         end
      end
   end

   // Token start and span after this byte
   always_comb begin
      start_mid = prev1 ? pos_ff : start_ff;
      span_mid  = prev1 ? '0 : span_ff;
      if (restart) begin
         start_b = pos_next;
         span_b  = '0;
      end else begin
         start_b = start_mid;
         span_b  = ctls_pkg::sat_inc(span_mid);
      end
   end

   // Token flushed at end of text
   always_comb begin
      unique case (st_a)
         ctls_pkg::StStart:   end_kind = ctls_pkg::KEof;
         ctls_pkg::StIdent:   end_kind = ctls_pkg::keyword_kind(prefix_a, count_a);
         ctls_pkg::StNumber:  end_kind = ctls_pkg::KNumber;
         ctls_pkg::StPlus:    end_kind = ctls_pkg::KPlus;
         ctls_pkg::StMinus:   end_kind = ctls_pkg::KMinus;
         ctls_pkg::StLess:    end_kind = ctls_pkg::KLt;
         ctls_pkg::StGreater: end_kind = ctls_pkg::KGt;
         ctls_pkg::StEqual:   end_kind = ctls_pkg::KAssign;
         ctls_pkg::StBang:    end_kind = ctls_pkg::KNot;
         ctls_pkg::StAmp:     end_kind = ctls_pkg::KAnd;
         ctls_pkg::StBar:     end_kind = ctls_pkg::KOr;
         ctls_pkg::StDot:     end_kind = ctls_pkg::KDot;
         ctls_pkg::StSlash:   end_kind = ctls_pkg::KDiv;
         ctls_pkg::StLineCmt: end_kind = ctls_pkg::KEof;
         default:             end_kind = ctls_pkg::KError;
      endcase
   end

   // Candidate tokens in emission order
   always_comb begin
      cand_valid[0] = close1 || done1 || prev1;
      cand[0].kind   = close1 ? ctls_pkg::KString : kind1;
      cand[0].offset = ctls_pkg::FieldBits'(start_ff);
      cand[0].length = done1 ? ctls_pkg::sat_inc(span_ff) : span_ff;
      cand[0].last   = 1'b0;

      // start-state single-byte token: starts at this byte, one byte long
      cand_valid[1] = (prev1 || run_start) && s.done;
      cand[1].kind   = s.kind;
      cand[1].offset = ctls_pkg::FieldBits'(pos_ff);
      cand[1].length = ctls_pkg::FieldBits'(1);
      cand[1].last   = 1'b0;

      cand_valid[2] = src_last;
      cand[2].kind   = end_kind;
      cand[2].offset = ctls_pkg::FieldBits'(start_b);
      cand[2].length = span_b;
      cand[2].last   = 1'b0;

      cand_valid[3] = src_last && (end_kind != ctls_pkg::KEof);
      cand[3].kind   = ctls_pkg::KEof;
      cand[3].offset = ctls_pkg::FieldBits'(pos_next);
      cand[3].length = '0;
      cand[3].last   = 1'b0;
   end

   // Compact into slots, flag the final one
   always_comb begin
      group = '0;
      n     = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_valid[i] && n < ctls_pkg::GroupBits'(ctls_pkg::MaxTokens)) begin
            group.slot[n] = cand[i];
            n = n + 1'b1;
         end
      end
      if (n != '0)
         group.slot[n - 1'b1].last = 1'b1;
      group.count = fire ? n : '0;
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      span_in   = span_ff;
      prefix_in = prefix_ff;
      count_in  = count_ff;
      if (fire) begin
         pos_in = pos_next;
         if (src_last) begin
            state_in  = ctls_pkg::StStart;
            start_in  = pos_next;
            span_in   = '0;
            prefix_in = '0;
            count_in  = '0;
         end else begin
            state_in  = st_a;
            start_in  = start_b;
            span_in   = span_b;
            prefix_in = prefix_a;
            count_in  = count_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ctls_pkg::StStart;
         pos_ff    <= '0;
         start_ff  <= '0;
         span_ff   <= '0;
         prefix_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         span_ff   <= span_in;
         prefix_ff <= prefix_in;
         count_ff  <= count_in;
      end
   end

   // In the start state no token is open: start sits at the current byte
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctls_pkg::StStart |-> start_ff == pos_ff && span_ff == '0)
      else $error("token start drifted while idle in start state");

   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      fire && src_last |=> state_ff == ctls_pkg::StStart && count_ff == '0)
      else $error("scanner not back in start state after end of text");

   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ctls_pkg::StBlockStar)
      else $error("scanner state out of range");

endmodule

// ===== hdl/ctls_result_queue.sv =====
// ============================================================================
// ctls_result_queue
// Small token queue: takes up to three tokens per cycle, hands out one when out_ready.
// The head entry drives the result channel straight from a register.
// ============================================================================
module ctls_result_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ctls_pkg::token_group_type push,
   output logic                      room,    // space for a full group
   output logic                      out_valid,
   input  logic                      out_ready,
   output ctls_pkg::token_type       out_token
);

   ctls_pkg::token_type                entry_ff [ctls_pkg::QueueDepth];
   ctls_pkg::token_type                entry_in [ctls_pkg::QueueDepth];
   logic [ctls_pkg::QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ctls_pkg::QueuePtrBits:0]    fill_ff, fill_in;
   logic                               pop;

   assign out_valid = (fill_ff != '0);
   assign out_token = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = fill_ff <= (ctls_pkg::QueuePtrBits + 1)'(
                         ctls_pkg::QueueDepth - ctls_pkg::MaxTokens);

   // Write the pushed slots at consecutive entries
   always_comb begin
      entry_in = entry_ff;
      for (int i = 0; i < ctls_pkg::MaxTokens; i++) begin
         if (ctls_pkg::GroupBits'(i) < push.count)
            entry_in[wr_ptr_ff + ctls_pkg::QueuePtrBits'(i)] = push.slot[i];
      end
   end

   // Pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + ctls_pkg::QueuePtrBits'(push.count);
      rd_ptr_in = rd_ptr_ff + ctls_pkg::QueuePtrBits'(pop);
      fill_in   = fill_ff + (ctls_pkg::QueuePtrBits + 1)'(push.count)
                  - (ctls_pkg::QueuePtrBits + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // The scanner only fires when a full group fits
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != '0 |-> room)
      else $error("token group pushed without room");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (ctls_pkg::QueuePtrBits + 1)'(ctls_pkg::QueueDepth))
      else $error("queue fill level out of range");

endmodule

// ===== hdl/c_like_token_scanner_unit.sv =====
// ============================================================================
// c_like_token_scanner_unit
// Bytes are registered at the input, their tokens in the queue, before rsp_.
// Throughput: one source byte per cycle while the queue has room; tokens
// leave one per cycle when rsp_tready is high, so a byte giving two or three
// tokens fills the 8-entry token queue; input stalls while it holds over five.
// Reset: synchronous, active high; scanner returns to start, positions to 0.
// ============================================================================
module c_like_token_scanner_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] source_byte
   input  logic                              req_tlast,   // end_of_source

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [5:0] token_kind, [29:6] token_offset, [53:30] token_length, [55:54] zero
   output logic [ctls_pkg::RspDataBits-1:0]  rsp_tdata,
   output logic                              rsp_tlast    // run_last
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   logic                      in_last_ff, in_last_in;
   logic                      take, consume, room;
   ctls_pkg::token_group_type group;
   ctls_pkg::token_type       head;

   // Input register: refilled on the cycle it is consumed
   assign consume    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || consume;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = take || (in_valid_ff && !consume);
      in_byte_in  = take ? req_tdata : in_byte_ff;
      in_last_in  = take ? req_tlast : in_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   ctls_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (consume),
      .src_byte (in_byte_ff),
      .src_last (in_last_ff),
      .group    (group)
   );

   ctls_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (group),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_token (head)
   );

   // Result transfer payload
   assign rsp_tdata = {{ctls_pkg::RspPadBits{1'b0}}, head.length, head.offset, head.kind};
   assign rsp_tlast = head.last;

endmodule
